// File: design/b64cc_pkg.sv
// ----------------------------------------------------------------------------
// b64cc_pkg
// shared types, alphabet rom and lookup functions for the base64 codec
// ----------------------------------------------------------------------------
package b64cc_pkg;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam int unsigned AlphaSize = 64;
  localparam int unsigned QueueDepth = 3;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       error;
  } out_word_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [5:0] carry;
  } codec_state_t;

  localparam logic [7:0] ALPHA [AlphaSize] = '{
    8'h31, 8'h35, 8'h39, 8'h41, 8'h45, 8'h49, 8'h4d, 8'h51,
    8'h55, 8'h59, 8'h63, 8'h67, 8'h6b, 8'h6f, 8'h73, 8'h77,
    8'h32, 8'h36, 8'h30, 8'h42, 8'h46, 8'h4a, 8'h4e, 8'h52,
    8'h56, 8'h5a, 8'h64, 8'h68, 8'h6c, 8'h70, 8'h74, 8'h78,
    8'h33, 8'h37, 8'h2e, 8'h43, 8'h47, 8'h4b, 8'h3f, 8'h53,
    8'h57, 8'h61, 8'h65, 8'h69, 8'h6d, 8'h71, 8'h75, 8'h79,
    8'h34, 8'h38, 8'h0a, 8'h44, 8'h48, 8'h4c, 8'h50, 8'h54,
    8'h58, 8'h62, 8'h66, 8'h6a, 8'h6e, 8'h72, 8'h76, 8'h7a
  };

  function automatic logic [7:0] enc_char(input logic [5:0] idx);
    return ALPHA[idx];
  endfunction

  // unknown characters map to zero
  function automatic logic [5:0] dec_value(input logic [7:0] c);
    logic [5:0] v;
    v = '0;
    for (int i = AlphaSize - 1; i >= 0; i--) begin
      if (ALPHA[i] == c) begin
        v = 6'(i);
      end
    end
    return v;
  endfunction

endpackage

// File: design/base64_custom_codec_core.sv
// ----------------------------------------------------------------------------
// base64_custom_codec_core
// streaming unpadded base64 encoder/decoder with a custom alphabet
// ----------------------------------------------------------------------------
// result words are registered in the output queue before they are offered
// a new input word is taken only while at most one result word waits;
//   encode yields up to two result words per input, decode at most one
// reset: mode is encode, phase and carry bits cleared, output queue empty
// ----------------------------------------------------------------------------
module base64_custom_codec_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  output logic       error_o
);

  logic                    mode_q;
  b64cc_pkg::codec_state_t state_q;
  b64cc_pkg::codec_state_t state_d;
  b64cc_pkg::codec_state_t step_state;
  b64cc_pkg::out_word_t    word0;
  b64cc_pkg::out_word_t    word1;
  b64cc_pkg::out_word_t    head;
  logic [1:0]              step_cnt;
  logic                    push;
  logic                    room;

  assign in_ready_o = room;
  assign push       = in_valid_i && room;

  b64cc_datapath u_datapath (
    .mode_i    (mode_q),
    .state_i   (state_q),
    .in_byte_i (in_byte_i),
    .is_last_i (is_last_i),
    .state_o   (step_state),
    .count_o   (step_cnt),
    .word0_o   (word0),
    .word1_o   (word1)
  );

  always_comb begin
    state_d = state_q;
    if (cfg_we_i) begin
      state_d = '0;
    end else if (push) begin
      state_d = step_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= b64cc_pkg::MODE_ENCODE;
      state_q <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      state_q <= state_d;
    end
  end

  b64cc_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_cnt_i  (step_cnt),
    .word0_i     (word0),
    .word1_i     (word1),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .word_o      (head)
  );

  assign out_byte_o = head.data;
  assign last_o     = head.last;
  assign error_o    = head.error;

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_o) |-> last_o)
    else $error("error word not marked last");

  a_enc_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && mode_q == b64cc_pkg::MODE_ENCODE) |-> !error_o)
    else $error("error flag in encode mode");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && is_last_i && !cfg_we_i) |=> state_q == '0)
    else $error("state not cleared after last word");

endmodule

// File: design/b64cc_datapath.sv
// ----------------------------------------------------------------------------
// b64cc_datapath
// per-word encode/decode step: produces up to two output words and next state
// ----------------------------------------------------------------------------
module b64cc_datapath (
  input  logic                   mode_i,
  input  b64cc_pkg::codec_state_t state_i,
  input  logic [7:0]             in_byte_i,
  input  logic                   is_last_i,
  output b64cc_pkg::codec_state_t state_o,
  output logic [1:0]             count_o,
  output b64cc_pkg::out_word_t   word0_o,
  output b64cc_pkg::out_word_t   word1_o
);

  logic [5:0] enc_idx0;
  logic [5:0] enc_idx1;
  logic [5:0] dec_v;
  logic [1:0] ph_next;
  logic [5:0] carry_next;

  assign dec_v = b64cc_pkg::dec_value(in_byte_i);

  always_comb begin
    enc_idx0   = '0;
    enc_idx1   = '0;
    ph_next    = '0;
    carry_next = '0;
    count_o    = 2'd1;
    word0_o    = '0;
    word1_o    = '0;

    if (mode_i == b64cc_pkg::MODE_ENCODE) begin
      case (state_i.phase)
        2'd0: begin
          enc_idx0   = in_byte_i[7:2];
          carry_next = {in_byte_i[1:0], 4'b0};
          ph_next    = 2'd1;
        end
        2'd1: begin
          enc_idx0   = state_i.carry | {2'b0, in_byte_i[7:4]};
          carry_next = {in_byte_i[3:0], 2'b0};
          ph_next    = 2'd2;
        end
        default: begin
          enc_idx0   = state_i.carry | {4'b0, in_byte_i[7:6]};
          enc_idx1   = in_byte_i[5:0];
          carry_next = '0;
          ph_next    = 2'd0;
          count_o    = 2'd2;
        end
      endcase
      // flush partial group
      if (is_last_i && ph_next != 2'd0) begin
        enc_idx1 = carry_next;
        count_o  = 2'd2;
      end
      word0_o.data = b64cc_pkg::enc_char(enc_idx0);
      word1_o.data = b64cc_pkg::enc_char(enc_idx1);
      word0_o.last = is_last_i && (count_o == 2'd1);
      word1_o.last = is_last_i;
    end else begin
      case (state_i.phase)
        2'd0: begin
          carry_next    = dec_v;
          ph_next       = 2'd1;
          count_o       = is_last_i ? 2'd1 : 2'd0;
          word0_o.error = 1'b1;
        end
        2'd1: begin
          word0_o.data = {state_i.carry, dec_v[5:4]};
          carry_next   = {2'b0, dec_v[3:0]};
          ph_next      = 2'd2;
        end
        2'd2: begin
          word0_o.data = {state_i.carry[3:0], dec_v[5:2]};
          carry_next   = {4'b0, dec_v[1:0]};
          ph_next      = 2'd3;
        end
        default: begin
          word0_o.data = {state_i.carry[1:0], dec_v};
          carry_next   = '0;
          ph_next      = 2'd0;
        end
      endcase
      word0_o.last = is_last_i;
    end

    state_o.phase = is_last_i ? 2'd0 : ph_next;
    state_o.carry = is_last_i ? 6'd0 : carry_next;
  end

endmodule

// File: design/b64cc_out_queue.sv
// ----------------------------------------------------------------------------
// b64cc_out_queue
// three-entry output queue; takes up to two words per push, one word per pop
// ----------------------------------------------------------------------------
module b64cc_out_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [1:0]           push_cnt_i,
  input  b64cc_pkg::out_word_t word0_i,
  input  b64cc_pkg::out_word_t word1_i,
  output logic                 room_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output b64cc_pkg::out_word_t word_o
);

  b64cc_pkg::out_word_t slot_q [b64cc_pkg::QueueDepth];
  b64cc_pkg::out_word_t slot_d [b64cc_pkg::QueueDepth];
  logic [1:0] cnt_q;
  logic [1:0] cnt_d;
  logic [1:0] base;
  logic [1:0] add;
  logic       pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign word_o      = slot_q[0];
  assign room_o      = (cnt_q <= 2'd1);
  assign base        = cnt_q - {1'b0, pop};
  assign add         = push_i ? push_cnt_i : 2'd0;
  assign cnt_d       = base + add;

  always_comb begin
    for (int i = 0; i < b64cc_pkg::QueueDepth; i++) begin
      slot_d[i] = slot_q[i];
      if (pop && i < b64cc_pkg::QueueDepth - 1) begin
        slot_d[i] = slot_q[i + 1];
      end
      if (push_i && push_cnt_i != 2'd0 && 2'(i) == base) begin
        slot_d[i] = word0_i;
      end
      if (push_i && push_cnt_i == 2'd2 && 2'(i) == base + 2'd1) begin
        slot_d[i] = word1_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < b64cc_pkg::QueueDepth; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_i) |=> cnt_q == $past(cnt_q) - 2'd1)
    else $error("queue count wrong after pop");

  a_push_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop) |=> cnt_q == $past(cnt_q) + $past(push_cnt_i))
    else $error("queue count wrong after push");

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> cnt_q <= 2'd1)
    else $error("push into a queue without room");

endmodule

// File: tb/sv/base64_custom_codec_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_custom_codec_core_tb
// self-checking bench for the streaming base64 codec: directed and random
// encode and decode streams, mode changes with open streams, random idling on
// both handshakes and a long receiver hold-off; every result word is compared
// with a local prediction of the codec
// ----------------------------------------------------------------------------
module base64_custom_codec_core_tb;

  localparam int unsigned StallLimit = 3000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 8;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_wdata_i = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       is_last_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       last_o;
  logic       error_o;

  base64_custom_codec_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .is_last_i  (is_last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_byte_o (out_byte_o),
    .last_o     (last_o),
    .error_o    (error_o)
  );

  b64cc_pkg::out_word_t pending_words[$];
  logic       cur_mode = b64cc_pkg::MODE_ENCODE;
  logic [1:0] cur_phase = 2'd0;
  logic [5:0] cur_carry = 6'd0;
  int         in_words = 0;
  int         out_words = 0;
  int         mismatches = 0;
  int         streams_sent = 0;
  bit         burst = 1'b0;
  bit         hold_req = 1'b0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic b64cc_pkg::out_word_t word_of(input logic [7:0] d, input logic l,
                                                   input logic e);
    b64cc_pkg::out_word_t w;
    w.data = d;
    w.last = l;
    w.error = e;
    return w;
  endfunction

  function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
    logic [5:0] v;
    bit         hit;
    v = 6'd0;
    hit = 1'b0;
    for (int i = 0; i < b64cc_pkg::AlphaSize; i++) begin
      if (!hit && b64cc_pkg::ALPHA[i] == c) begin
        v = 6'(i);
        hit = 1'b1;
      end
    end
    return v;
  endfunction

  task automatic predict_codec_words(input logic [7:0] b, input logic fin);
    b64cc_pkg::out_word_t w[3];
    int         n;
    logic [5:0] v;
    n = 0;
    if (cur_mode == b64cc_pkg::MODE_ENCODE) begin
      case (cur_phase)
        2'd0: begin
          w[n] = word_of(b64cc_pkg::ALPHA[b[7:2]], 1'b0, 1'b0); n++;
          cur_carry = {b[1:0], 4'b0};
          cur_phase = 2'd1;
        end
        2'd1: begin
          w[n] = word_of(b64cc_pkg::ALPHA[{cur_carry[5:4], b[7:4]}], 1'b0, 1'b0); n++;
          cur_carry = {b[3:0], 2'b0};
          cur_phase = 2'd2;
        end
        default: begin
          w[n] = word_of(b64cc_pkg::ALPHA[{cur_carry[5:2], b[7:6]}], 1'b0, 1'b0); n++;
          w[n] = word_of(b64cc_pkg::ALPHA[b[5:0]], 1'b0, 1'b0); n++;
          cur_carry = 6'd0;
          cur_phase = 2'd0;
        end
      endcase
      if (fin) begin
        if (cur_phase != 2'd0) begin
          w[n] = word_of(b64cc_pkg::ALPHA[cur_carry], 1'b0, 1'b0); n++;
        end
        w[n-1].last = 1'b1;
      end
    end else begin
      v = char_to_sextet(b);
      case (cur_phase)
        2'd0: begin
          cur_carry = v;
          cur_phase = 2'd1;
          // lone trailing character gives no byte
          if (fin) begin
            w[n] = word_of(8'h00, 1'b1, 1'b1); n++;
          end
        end
        2'd1: begin
          w[n] = word_of({cur_carry, v[5:4]}, fin, 1'b0); n++;
          cur_carry = {2'b0, v[3:0]};
          cur_phase = 2'd2;
        end
        2'd2: begin
          w[n] = word_of({cur_carry[3:0], v[5:2]}, fin, 1'b0); n++;
          cur_carry = {4'b0, v[1:0]};
          cur_phase = 2'd3;
        end
        default: begin
          w[n] = word_of({cur_carry[1:0], v}, fin, 1'b0); n++;
          cur_carry = 6'd0;
          cur_phase = 2'd0;
        end
      endcase
    end
    if (fin) begin
      cur_phase = 2'd0;
      cur_carry = 6'd0;
    end
    for (int i = 0; i < n; i++) pending_words.push_back(w[i]);
  endtask

  task automatic send_word(input logic [7:0] b, input logic fin);
    int gap;
    bit hit;
    gap = burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    is_last_i  <= fin;
    do begin
      @(negedge clk_i);
      hit = in_ready_o;
      @(posedge clk_i);
    end while (!hit);
    in_words++;
    predict_codec_words(b, fin);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    // a character with no byte may still be in flight
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic m);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_mode  = m;
    cur_phase = 2'd0;
    cur_carry = 6'd0;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_char();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return b64cc_pkg::ALPHA[$urandom_range(0, b64cc_pkg::AlphaSize - 1)];
  endfunction

  task automatic send_stream(input int len, input bit closed);
    for (int i = 0; i < len; i++) begin
      send_word(cur_mode == b64cc_pkg::MODE_DECODE ? rand_char() : 8'($urandom_range(0, 255)),
                closed && (i == len - 1));
    end
    if (closed) streams_sent++;
  endtask

  function automatic int rand_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(9, 20);
    return $urandom_range(1, 8);
  endfunction

  // result side: random stall per word, long hold-off on request
  initial begin
    int                   gap;
    bit                   hit;
    b64cc_pkg::out_word_t got;
    b64cc_pkg::out_word_t want;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      gap = burst ? 0 : $urandom_range(0, 12);
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HoldCycles;
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do begin
        @(negedge clk_i);
        hit = out_valid_o;
        got = word_of(out_byte_o, last_o, error_o);
        @(posedge clk_i);
      end while (!hit);
      out_words++;
      if (pending_words.size() == 0) begin
        $error("unexpected word: out_byte %02h last %0b error %0b",
               got.data, got.last, got.error);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        if (got.data !== want.data) begin
          $error("out_byte: expected %02h, got %02h", want.data, got.data);
          mismatches++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, got.last);
          mismatches++;
        end
        if (got.error !== want.error) begin
          $error("error: expected %0b, got %0b", want.error, got.error);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int stall;
    int seen;
    stall = 0;
    seen = 0;
    forever begin
      @(posedge clk_i);
      if (in_words + out_words != seen) begin
        seen = in_words + out_words;
        stall = 0;
      end else begin
        stall++;
      end
      if (stall >= StallLimit) begin
        $display("watchdog: no handshake for %0d cycles", stall);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic test_encode_directed();
    set_mode(b64cc_pkg::MODE_ENCODE);
    send_word(8'hff, 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'hff, 1'b1);
    send_word(8'ha5, 1'b0);
    send_word(8'h5a, 1'b0);
    send_word(8'h3c, 1'b1);
    send_word(8'h01, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h7f, 1'b0);
    send_word(8'hfe, 1'b1);
  endtask

  task automatic test_decode_directed();
    set_mode(b64cc_pkg::MODE_DECODE);
    // one character stream flags an error
    send_word(b64cc_pkg::ALPHA[b64cc_pkg::AlphaSize - 1], 1'b1);
    // characters outside the alphabet decode as zero
    send_word(8'h00, 1'b0);
    send_word(8'hff, 1'b1);
    send_word(b64cc_pkg::ALPHA[0], 1'b0);
    send_word(b64cc_pkg::ALPHA[63], 1'b0);
    send_word(b64cc_pkg::ALPHA[34], 1'b1);
    send_word(b64cc_pkg::ALPHA[50], 1'b0);
    send_word(b64cc_pkg::ALPHA[21], 1'b0);
    send_word(b64cc_pkg::ALPHA[42], 1'b0);
    send_word(b64cc_pkg::ALPHA[63], 1'b0);
    // fifth character ends on an error after three bytes
    send_word(b64cc_pkg::ALPHA[63], 1'b1);
  endtask

  task automatic test_mode_abandon();
    set_mode(b64cc_pkg::MODE_ENCODE);
    send_word(8'hc3, 1'b0);
    send_word(8'h3c, 1'b0);
    set_mode(b64cc_pkg::MODE_ENCODE);
    send_word(8'h96, 1'b1);
    set_mode(b64cc_pkg::MODE_DECODE);
    send_word(b64cc_pkg::ALPHA[63], 1'b0);
    send_word(b64cc_pkg::ALPHA[63], 1'b0);
    set_mode(b64cc_pkg::MODE_DECODE);
    send_word(b64cc_pkg::ALPHA[12], 1'b1);
  endtask

  task automatic test_random_streams(input logic m, input int items);
    int start;
    set_mode(m);
    start = in_words;
    while (in_words - start < items) begin
      burst = ($urandom_range(0, 5) == 0);
      send_stream(rand_len(), 1'b1);
    end
    burst = 1'b0;
  endtask

  task automatic test_backpressure();
    set_mode(b64cc_pkg::MODE_ENCODE);
    burst = 1'b1;
    hold_req = 1'b1;
    send_stream(40, 1'b1);
    burst = 1'b0;
    set_mode(b64cc_pkg::MODE_DECODE);
    burst = 1'b1;
    hold_req = 1'b1;
    send_stream(40, 1'b1);
    burst = 1'b0;
  endtask

  task automatic test_mode_sweep(input int items);
    int start;
    start = in_words;
    while (in_words - start < items) begin
      set_mode(logic'($urandom_range(0, 1)));
      repeat ($urandom_range(1, 4)) begin
        burst = ($urandom_range(0, 5) == 0);
        send_stream(rand_len(), 1'b1);
      end
      // sometimes leave a stream open across the mode write
      if ($urandom_range(0, 2) == 0) send_stream($urandom_range(1, 3), 1'b0);
      burst = 1'b0;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_encode_directed();
    test_decode_directed();
    test_mode_abandon();
    test_random_streams(b64cc_pkg::MODE_ENCODE, 280);
    test_random_streams(b64cc_pkg::MODE_DECODE, 280);
    test_backpressure();
    test_mode_sweep(260);
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("run covered %0d input words, %0d result words, %0d closed streams",
             in_words, out_words, streams_sent);
    $display("encode and decode, unknown characters, error tails, mode writes, hold-off");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
